/* rtl/core/cbfd_pkg.sv */
// shared constants and crc-8 helpers for the can boot frame decoder
package cbfd_pkg;

  localparam int unsigned IdWidth   = 29;
  localparam int unsigned LenWidth  = 4;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CrcBytes  = 7;
  localparam int unsigned CrcBits   = CrcBytes * ByteWidth;

  localparam logic [IdWidth-1:0]   HOST_ID_LO = IdWidth'(32'h501);
  localparam logic [IdWidth-1:0]   HOST_ID_HI = IdWidth'(32'h508);
  localparam logic [IdWidth-1:0]   PEER_ID_LO = IdWidth'(32'h601);
  localparam logic [IdWidth-1:0]   PEER_ID_HI = IdWidth'(32'h608);
  localparam logic [LenWidth-1:0]  FULL_LEN   = LenWidth'(8);
  localparam logic [ByteWidth-1:0] CRC_POLY   = 8'h07;
  localparam logic [ByteWidth-1:0] ERR_STATUS_RESET = 8'hFF;

  localparam logic KIND_HOST = 1'b0;
  localparam logic KIND_PEER = 1'b1;

  typedef logic [CrcBits-1:0][ByteWidth-1:0] crc_cols_t;

  // column p holds x^(p+8) mod g, p counted from the last message bit
  function automatic crc_cols_t crc_col_table();
    crc_cols_t cols;
    logic [ByteWidth-1:0] r;
    r = 8'h01;
    for (int k = 0; k < ByteWidth; k++) begin
      r = r[ByteWidth-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    for (int p = 0; p < CrcBits; p++) begin
      cols[p] = r;
      r = r[ByteWidth-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_col_table();

  // parallel crc-8 of the message, first byte in the top bits
  function automatic logic [ByteWidth-1:0] crc8_msg(input logic [CrcBits-1:0] msg);
    logic [ByteWidth-1:0] c;
    c = '0;
    for (int p = 0; p < CrcBits; p++) begin
      c = c ^ (msg[p] ? CRC_COLS[p] : '0);
    end
    return c;
  endfunction

endpackage

/* rtl/core/can_boot_frame_decoder.sv */
// can boot frame decoder top level: crc check, id classification and field split
//
//  channel  | handshake                 | contents
//  frame    | frame_valid / frame_stall | can_id, data_length, data_byte_0..7
//  result   | result_valid/result_stall | accepted, frame_kind, decoded fields, echo_id
//  config   | cfg_we                    | cfg_wdata -> error status value
//
// one word per cycle unless result_stall holds the result register; input register, then result register
// the crc is a single xor tree between the two registers
// result_stall holds the result register and backs up into frame_stall
// rst clears valids and sets the error status value to 0xff
module can_boot_frame_decoder (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   frame_valid,
  output logic                                   frame_stall,
  input  logic [cbfd_pkg::IdWidth-1:0]           can_id,
  input  logic [cbfd_pkg::LenWidth-1:0]          data_length,
  input  logic [cbfd_pkg::ByteWidth-1:0]         data_byte_0,
  input  logic [cbfd_pkg::ByteWidth-1:0]         data_byte_1,
  input  logic [cbfd_pkg::ByteWidth-1:0]         data_byte_2,
  input  logic [cbfd_pkg::ByteWidth-1:0]         data_byte_3,
  input  logic [cbfd_pkg::ByteWidth-1:0]         data_byte_4,
  input  logic [cbfd_pkg::ByteWidth-1:0]         data_byte_5,
  input  logic [cbfd_pkg::ByteWidth-1:0]         data_byte_6,
  input  logic [cbfd_pkg::ByteWidth-1:0]         data_byte_7,
  input  logic                                   cfg_we,
  input  logic [cbfd_pkg::ByteWidth-1:0]         cfg_wdata,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic                                   accepted,
  output logic                                   frame_kind,
  output logic [cbfd_pkg::ByteWidth-1:0]         node_or_target,
  output logic [cbfd_pkg::ByteWidth-1:0]         command,
  output logic [cbfd_pkg::ByteWidth-1:0]         status_or_source,
  output logic [4*cbfd_pkg::ByteWidth-1:0]       payload,
  output logic [2*cbfd_pkg::ByteWidth-1:0]       session,
  output logic [2*cbfd_pkg::ByteWidth-1:0]       value,
  output logic [cbfd_pkg::ByteWidth-1:0]         error_code,
  output logic [cbfd_pkg::IdWidth-1:0]           echo_id
);
  import cbfd_pkg::*;

  logic                  err_status;
  logic                  held;
  logic [IdWidth-1:0]    held_id;
  logic [LenWidth-1:0]   held_len;
  logic [7:0][ByteWidth-1:0] held_bytes;

  logic                  advance;
  logic                  take;
  logic                  is_host;
  logic                  is_peer;
  logic                  crc_ok;
  logic                  ok;
  logic [ByteWidth-1:0]  err_value;

  logic                  accepted_next;
  logic                  frame_kind_next;
  logic [ByteWidth-1:0]  node_next;
  logic [ByteWidth-1:0]  command_next;
  logic [ByteWidth-1:0]  status_next;
  logic [4*ByteWidth-1:0] payload_next;
  logic [2*ByteWidth-1:0] session_next;
  logic [2*ByteWidth-1:0] value_next;
  logic [ByteWidth-1:0]  error_code_next;
  logic [IdWidth-1:0]    echo_id_next;

  assign advance     = !result_valid || !result_stall;
  assign frame_stall = held && !advance;
  assign take        = frame_valid && !frame_stall;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      err_value <= ERR_STATUS_RESET;
    end else if (cfg_we) begin
      err_value <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_id    <= can_id;
      held_len   <= data_length;
      held_bytes <= {data_byte_7, data_byte_6, data_byte_5, data_byte_4,
                     data_byte_3, data_byte_2, data_byte_1, data_byte_0};
    end
  end

  // decode
  always_comb begin
    is_host    = held_id inside {[HOST_ID_LO:HOST_ID_HI]};
    is_peer    = held_id inside {[PEER_ID_LO:PEER_ID_HI]};
    crc_ok     = crc8_msg({held_bytes[0], held_bytes[1], held_bytes[2], held_bytes[3],
                           held_bytes[4], held_bytes[5], held_bytes[6]}) == held_bytes[7];
    ok         = (is_host || is_peer) && (held_len == FULL_LEN) && crc_ok;
    err_status = is_host && (held_bytes[2] == err_value);

    accepted_next   = 1'b0;
    frame_kind_next = KIND_HOST;
    node_next       = '0;
    command_next    = '0;
    status_next     = '0;
    payload_next    = '0;
    session_next    = '0;
    value_next      = '0;
    error_code_next = '0;
    echo_id_next    = '0;
    if (ok) begin
      accepted_next   = 1'b1;
      frame_kind_next = is_peer ? KIND_PEER : KIND_HOST;
      node_next       = held_bytes[0];
      command_next    = held_bytes[1];
      status_next     = held_bytes[2];
      payload_next    = {held_bytes[6], held_bytes[5], held_bytes[4], held_bytes[3]};
      echo_id_next    = held_id;
      if (is_peer) begin
        session_next = {held_bytes[4], held_bytes[3]};
        value_next   = {held_bytes[6], held_bytes[5]};
      end else if (err_status) begin
        error_code_next = held_bytes[3];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held) begin
      accepted         <= accepted_next;
      frame_kind       <= frame_kind_next;
      node_or_target   <= node_next;
      command          <= command_next;
      status_or_source <= status_next;
      payload          <= payload_next;
      session          <= session_next;
      value            <= value_next;
      error_code       <= error_code_next;
      echo_id          <= echo_id_next;
    end
  end

  // checks
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !accepted |-> (payload == '0) && (echo_id == '0) &&
      (frame_kind == KIND_HOST))
    else $error("rejected word carries nonzero fields");

  a_peer_no_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && accepted && frame_kind == KIND_PEER |-> error_code == '0)
    else $error("peer word carries an error code");

  a_host_no_session: assert property (@(posedge clk) disable iff (rst)
    result_valid && accepted && frame_kind == KIND_HOST |-> session == '0 && value == '0)
    else $error("host word carries session or value");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && accepted |->
      (echo_id >= HOST_ID_LO && echo_id <= HOST_ID_HI) ||
      (echo_id >= PEER_ID_LO && echo_id <= PEER_ID_HI))
    else $error("accepted word with id outside both ranges");

  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    held && !advance |=> held)
    else $error("input word dropped while result stalled");

endmodule

/* tb/can_boot_frame_decoder_tb.sv */
// self-checking testbench for the can boot frame decoder: directed and random frames
`timescale 1ns / 1ps

module can_boot_frame_decoder_tb;
  import cbfd_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASE_FRAMES = 105;

  typedef struct packed {
    logic [IdWidth-1:0]   id;
    logic [LenWidth-1:0]  len;
    logic [7:0][7:0]      b;
  } frame_t;

  typedef struct {
    logic        acc;
    logic        kind;
    logic [7:0]  node;
    logic [7:0]  cmd;
    logic [7:0]  stat;
    logic [31:0] pay;
    logic [15:0] sess;
    logic [15:0] val;
    logic [7:0]  err;
    logic [IdWidth-1:0] id;
  } decode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic frame_valid = 1'b0;
  logic frame_stall;
  logic [IdWidth-1:0] can_id = '0;
  logic [LenWidth-1:0] data_length = '0;
  logic [7:0] data_byte_0 = '0;
  logic [7:0] data_byte_1 = '0;
  logic [7:0] data_byte_2 = '0;
  logic [7:0] data_byte_3 = '0;
  logic [7:0] data_byte_4 = '0;
  logic [7:0] data_byte_5 = '0;
  logic [7:0] data_byte_6 = '0;
  logic [7:0] data_byte_7 = '0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic accepted;
  logic frame_kind;
  logic [7:0] node_or_target;
  logic [7:0] command;
  logic [7:0] status_or_source;
  logic [31:0] payload;
  logic [15:0] session;
  logic [15:0] value;
  logic [7:0] error_code;
  logic [IdWidth-1:0] echo_id;

  frame_t frames_pending[$];
  decode_t expected_decodes[$];
  logic [7:0] err_status_mirror = ERR_STATUS_RESET;
  int unsigned frames_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  can_boot_frame_decoder DUT (
    .clk(clk),
    .rst(rst),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .can_id(can_id),
    .data_length(data_length),
    .data_byte_0(data_byte_0),
    .data_byte_1(data_byte_1),
    .data_byte_2(data_byte_2),
    .data_byte_3(data_byte_3),
    .data_byte_4(data_byte_4),
    .data_byte_5(data_byte_5),
    .data_byte_6(data_byte_6),
    .data_byte_7(data_byte_7),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .accepted(accepted),
    .frame_kind(frame_kind),
    .node_or_target(node_or_target),
    .command(command),
    .status_or_source(status_or_source),
    .payload(payload),
    .session(session),
    .value(value),
    .error_code(error_code),
    .echo_id(echo_id)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] crc_of_body(input logic [55:0] body);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 7; i++) begin
      c = c ^ body[8*i +: 8];
      for (int k = 0; k < 8; k++) begin
        c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
      end
    end
    return c;
  endfunction

  function automatic decode_t decode_frame(input frame_t f, input logic [7:0] err_status);
    decode_t d;
    logic host;
    logic peer;
    d = '{default: '0};
    host = f.id >= HOST_ID_LO && f.id <= HOST_ID_HI;
    peer = f.id >= PEER_ID_LO && f.id <= PEER_ID_HI;
    if ((host || peer) && f.len == FULL_LEN && crc_of_body(f.b[6:0]) == f.b[7]) begin
      d.acc  = 1'b1;
      d.kind = peer ? KIND_PEER : KIND_HOST;
      d.node = f.b[0];
      d.cmd  = f.b[1];
      d.stat = f.b[2];
      d.pay  = {f.b[6], f.b[5], f.b[4], f.b[3]};
      if (peer) begin
        d.sess = {f.b[4], f.b[3]};
        d.val  = {f.b[6], f.b[5]};
      end else if (f.b[2] == err_status) begin
        d.err = f.b[3];
      end
      d.id = f.id;
    end
    return d;
  endfunction

  function automatic frame_t build_frame(input logic [IdWidth-1:0] id,
                                         input logic [LenWidth-1:0] len,
                                         input logic [55:0] body,
                                         input logic [7:0] crc_flip);
    frame_t f;
    f.id = id;
    f.len = len;
    f.b[6:0] = body;
    f.b[7] = crc_of_body(body) ^ crc_flip;
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    logic [55:0] body;
    logic [IdWidth-1:0] id;
    int unsigned pick;
    body = 56'({$urandom(), $urandom()});
    pick = $urandom_range(99);
    if ($urandom_range(1))
      id = HOST_ID_LO + IdWidth'($urandom_range(7));
    else
      id = PEER_ID_LO + IdWidth'($urandom_range(7));
    if ($urandom_range(99) < 30)
      body[23:16] = err_status_mirror;
    f = build_frame(id, FULL_LEN, body, 8'h00);
    if (pick >= 60 && pick < 70) begin
      f.b[7] = f.b[7] ^ 8'($urandom_range(255, 1));
    end else if (pick >= 70 && pick < 78) begin
      f.len = ($urandom_range(1)) ? 4'($urandom_range(7)) : 4'($urandom_range(15, 9));
    end else if (pick >= 78 && pick < 86) begin
      case ($urandom_range(5))
        0: id = HOST_ID_LO - IdWidth'(1);
        1: id = HOST_ID_HI + IdWidth'(1);
        2: id = PEER_ID_LO - IdWidth'(1);
        3: id = PEER_ID_HI + IdWidth'(1);
        4: id = id ^ (29'h1 << $urandom_range(28, 11));
        default: id = id | 29'h1000;
      endcase
      f = build_frame(id, FULL_LEN, body, 8'h00);
    end else if (pick >= 86) begin
      f.id = 29'($urandom());
      f.len = 4'($urandom());
      f.b = {$urandom(), $urandom()};
    end
    return f;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0h actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  task automatic write_status(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    err_status_mirror = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (frames_pending.size() != 0 || frame_valid || expected_decodes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int unsigned n);
    @(negedge clk);
    for (int unsigned i = 0; i < n; i++)
      frames_pending.push_back(random_frame());
  endtask

  // driver
  always @(posedge clk) begin : frame_driver
    logic take;
    frame_t f;
    take = frame_valid && !frame_stall;
    if (rst) begin
      frame_valid <= 1'b0;
    end else begin
      if (take) begin
        f = {can_id, data_length, data_byte_7, data_byte_6, data_byte_5, data_byte_4,
             data_byte_3, data_byte_2, data_byte_1, data_byte_0};
        expected_decodes.push_back(decode_frame(f, err_status_mirror));
        frames_sent++;
      end
      if (!frame_valid || take) begin
        if (frames_pending.size() != 0 &&
            !((frames_sent < 250 || frames_sent >= 370) && $urandom_range(99) < 9)) begin
          f = frames_pending.pop_front();
          frame_valid <= 1'b1;
          can_id <= f.id;
          data_length <= f.len;
          data_byte_0 <= f.b[0];
          data_byte_1 <= f.b[1];
          data_byte_2 <= f.b[2];
          data_byte_3 <= f.b[3];
          data_byte_4 <= f.b[4];
          data_byte_5 <= f.b[5];
          data_byte_6 <= f.b[6];
          data_byte_7 <= f.b[7];
        end else begin
          frame_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : result_monitor
    decode_t d;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_decodes.size() == 0) begin
          $display("%0t unexpected result word, expected none actual id %0h",
                   $time, echo_id);
          mismatches++;
        end else begin
          d = expected_decodes.pop_front();
          check_field("accepted", 32'(d.acc), 32'(accepted));
          check_field("frame_kind", 32'(d.kind), 32'(frame_kind));
          check_field("node_or_target", 32'(d.node), 32'(node_or_target));
          check_field("command", 32'(d.cmd), 32'(command));
          check_field("status_or_source", 32'(d.stat), 32'(status_or_source));
          check_field("payload", d.pay, payload);
          check_field("session", 32'(d.sess), 32'(session));
          check_field("value", 32'(d.val), 32'(value));
          check_field("error_code", 32'(d.err), 32'(error_code));
          check_field("echo_id", 32'(d.id), 32'(echo_id));
        end
      end
      result_stall <= (results_seen < 250 || results_seen >= 370) &&
                      ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    if (rst || (frame_valid && !frame_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    frames_pending.push_back(build_frame(HOST_ID_LO, FULL_LEN, {56{1'b1}}, 8'h00));
    frames_pending.push_back(build_frame(HOST_ID_HI, FULL_LEN, 56'h0, 8'h00));
    frames_pending.push_back(build_frame(29'h505, FULL_LEN, 56'h11223344_12AB07, 8'h00));
    frames_pending.push_back(build_frame(PEER_ID_LO, FULL_LEN, {56{1'b1}}, 8'h00));
    frames_pending.push_back(build_frame(PEER_ID_HI, FULL_LEN, 56'h0, 8'h00));
    frames_pending.push_back(build_frame(29'h604, FULL_LEN, 56'hA1B2C3D4_FF3C05, 8'h00));
    frames_pending.push_back(build_frame(HOST_ID_LO - IdWidth'(1), FULL_LEN, 56'h5A, 8'h00));
    frames_pending.push_back(build_frame(HOST_ID_HI + IdWidth'(1), FULL_LEN, 56'h5A, 8'h00));
    frames_pending.push_back(build_frame(PEER_ID_LO - IdWidth'(1), FULL_LEN, 56'h5A, 8'h00));
    frames_pending.push_back(build_frame(PEER_ID_HI + IdWidth'(1), FULL_LEN, 56'h5A, 8'h00));
    frames_pending.push_back(build_frame(29'h0, FULL_LEN, 56'h0, 8'h00));
    frames_pending.push_back(build_frame({IdWidth{1'b1}}, 4'hF, {56{1'b1}}, 8'h00));
    frames_pending.push_back(build_frame(29'h502, 4'd0, 56'h0, 8'h00));
    frames_pending.push_back(build_frame(29'h502, 4'd7, 56'h1234, 8'h00));
    frames_pending.push_back(build_frame(29'h602, 4'd9, 56'h1234, 8'h00));
    frames_pending.push_back(build_frame(29'h602, 4'd15, 56'h1234, 8'h00));
    frames_pending.push_back(build_frame(29'h503, FULL_LEN, 56'hFF_0102, 8'h01));
    frames_pending.push_back(build_frame(29'h603, FULL_LEN, 56'h0102_0304, 8'h80));
    frames_pending.push_back(build_frame(29'h503, FULL_LEN, 56'h0123456789ABCD, 8'h00));
    drain();

    write_status(8'h00);
    queue_random(PHASE_FRAMES);
    drain();
    write_status(8'h80);
    queue_random(PHASE_FRAMES);
    drain();
    write_status(8'($urandom()));
    queue_random(PHASE_FRAMES);
    drain();
    write_status(8'h7F);
    queue_random(PHASE_FRAMES);
    drain();
    write_status(8'hFF);
    queue_random(PHASE_FRAMES);
    drain();

    if (mismatches == 0 && expected_decodes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
